FILE: src/fkv_pkg.sv
// ----------------------------------------------------------------------------
// fkv_pkg
// Shared types and constants of the FNV-1 hashed key/value table.
// ----------------------------------------------------------------------------
package fkv_pkg;

    localparam int SLOTS         = 256;
    localparam int MAX_KEY_BYTES = 8;
    localparam int VALUE_BITS    = 32;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W   = 8 * MAX_KEY_BYTES;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 + KEY_W + LEN_W + VALUE_BITS;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_MULT  = 32'h01000193;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_REPLACE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_UNUSED = 2'd3
    } t_mark;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_init;
        logic mem_read;
        logic check;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hash_done;
        logic probe_stop;
        logic out_free;
    } t_stat;

endpackage

FILE: src/fnv1_hashed_key_value_table.sv
// ----------------------------------------------------------------------------
// fnv1_hashed_key_value_table
// Open-addressing key/value table indexed by a 32-bit FNV-1 hash of the key.
// ----------------------------------------------------------------------------
// One request at a time. A request takes a load step, serial hash steps over
// key_length (max 8) bytes with one 32x32 multiply each, a step to start the
// probe, a registered read of the single-port slot memory and then a compare
// for each probed slot, and a commit step, with 1 to 256 slots probed. The
// result waits in an output register, so the next request is taken as soon as
// the commit is done; commit stalls only while a previous result has not been
// taken. No clearing pass after reset.
module fnv1_hashed_key_value_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_value,
    output logic [8:0]  o_entry_total
);

    fkv_pkg::t_cmd  cmd;
    fkv_pkg::t_stat stat;

    fkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    fkv_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_key_bytes   (i_key_bytes),
        .i_key_length  (i_key_length),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_total (o_entry_total)
    );

endmodule

FILE: src/fkv_ctrl.sv
// ----------------------------------------------------------------------------
// fkv_ctrl
// Sequencer: load request, hash byte by byte, probe the table, commit result.
// ----------------------------------------------------------------------------
module fkv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fkv_pkg::t_stat i_stat,
    output fkv_pkg::t_cmd  o_cmd,
    output logic          o_ready
);

    fkv_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fkv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            fkv_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fkv_pkg::S_HASH;
                end
            end
            fkv_pkg::S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = fkv_pkg::S_READ;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            fkv_pkg::S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = fkv_pkg::S_CHECK;
            end
            fkv_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.probe_stop ? fkv_pkg::S_COMMIT : fkv_pkg::S_READ;
            end
            fkv_pkg::S_COMMIT: begin
                // hold here until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = fkv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fkv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/fkv_datapath.sv
// ----------------------------------------------------------------------------
// fkv_datapath
// Request registers, serial FNV-1 hash, slot memory with valid bits, probe
// bookkeeping, entry count and output register.
// ----------------------------------------------------------------------------
module fkv_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fkv_pkg::t_cmd                     i_cmd,
    output fkv_pkg::t_stat                    o_stat,
    input  logic [1:0]                        i_kind,
    input  logic [fkv_pkg::KEY_W-1:0]         i_key_bytes,
    input  logic [fkv_pkg::LEN_W-1:0]         i_key_length,
    input  logic [fkv_pkg::DATA_W-1:0]        i_data_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [fkv_pkg::DATA_W-1:0]        o_read_value,
    output logic [fkv_pkg::COUNT_W-1:0]       o_entry_total
);

    localparam int SW = fkv_pkg::SLOT_W;
    localparam int CW = fkv_pkg::COUNT_W;
    localparam int KW = fkv_pkg::KEY_W;
    localparam int LW = fkv_pkg::LEN_W;
    localparam int VW = fkv_pkg::VALUE_BITS;
    localparam int EW = fkv_pkg::ENTRY_W;

    // request
    fkv_pkg::t_kind  r_kind;
    logic [KW-1:0]   r_key;
    logic [LW-1:0]   r_len;
    logic [VW-1:0]   r_val;
    logic [31:0]     r_hash;
    logic [LW-1:0]   r_cnt;

    // probe
    logic [SW-1:0]   r_idx;
    logic [SW-1:0]   r_stride;
    logic [CW-1:0]   r_visits;
    logic            r_found;
    logic            r_have_free;
    logic [SW-1:0]   r_hit;
    logic [SW-1:0]   r_free;
    logic [VW-1:0]   r_hit_val;

    // slot memory: {mark, key, length, value}
    logic [EW-1:0]       r_mem [fkv_pkg::SLOTS];
    logic [fkv_pkg::SLOTS-1:0] r_vld;
    logic [EW-1:0]       r_rd;
    logic                r_rd_vld;

    logic [CW-1:0]   r_live;

    // output register
    logic            r_o_valid;
    fkv_pkg::t_status r_o_status;
    logic [fkv_pkg::DATA_W-1:0] r_o_value;
    logic [CW-1:0]   r_o_total;

    logic [LW-1:0]   len_sat;
    logic [KW-1:0]   key_masked;
    logic [63:0]     product;
    logic [7:0]      hash_byte;
    fkv_pkg::t_mark  rd_mark;
    logic [KW-1:0]   rd_key;
    logic [LW-1:0]   rd_len;
    logic [VW-1:0]   rd_val;
    logic            is_empty;
    logic            is_match;
    logic            is_tomb;

    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    logic [EW-1:0]   mem_wd;
    logic [CW-1:0]   n_live;
    fkv_pkg::t_status n_status;
    logic [VW-1:0]   n_value;

    always_comb begin
        len_sat = (i_key_length > LW'(fkv_pkg::MAX_KEY_BYTES))
                ? LW'(fkv_pkg::MAX_KEY_BYTES) : i_key_length;
        for (int b = 0; b < fkv_pkg::MAX_KEY_BYTES; b++) begin
            key_masked[8*b +: 8] = (LW'(b) < len_sat) ? i_key_bytes[8*b +: 8] : 8'h00;
        end
    end

    assign product   = r_hash * fkv_pkg::FNV_MULT;
    assign hash_byte = r_key[8*r_cnt[$clog2(fkv_pkg::MAX_KEY_BYTES+1)-2:0] +: 8];

    assign rd_mark  = r_rd_vld ? fkv_pkg::t_mark'(r_rd[EW-1 -: 2]) : fkv_pkg::MARK_EMPTY;
    assign rd_key   = r_rd[VW+LW +: KW];
    assign rd_len   = r_rd[VW +: LW];
    assign rd_val   = r_rd[VW-1:0];
    assign is_empty = (rd_mark == fkv_pkg::MARK_EMPTY);
    assign is_match = (rd_mark == fkv_pkg::MARK_LIVE) && (rd_len == r_len) && (rd_key == r_key);
    assign is_tomb  = !is_empty && (rd_mark != fkv_pkg::MARK_LIVE);

    assign o_stat.hash_done  = (r_cnt == r_len);
    assign o_stat.probe_stop = is_empty || is_match || (r_visits == CW'(fkv_pkg::SLOTS - 1));
    assign o_stat.out_free   = !r_o_valid || i_ready;

    // commit decision
    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_hit;
        mem_wd   = {fkv_pkg::MARK_LIVE, r_key, r_len, r_val};
        n_live   = r_live;
        n_status = fkv_pkg::ST_DONE;
        n_value  = '0;
        case (r_kind)
            fkv_pkg::KIND_INSERT: begin
                if (r_found) begin
                    n_status = fkv_pkg::ST_PRESENT;
                end else if (r_live >= CW'(fkv_pkg::SLOTS) || !r_have_free) begin
                    n_status = fkv_pkg::ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_free;
                    n_live = r_live + 1'b1;
                end
            end
            fkv_pkg::KIND_LOOKUP: begin
                if (r_found) begin
                    n_value = r_hit_val;
                end else begin
                    n_status = fkv_pkg::ST_ABSENT;
                end
            end
            fkv_pkg::KIND_REMOVE: begin
                if (r_found) begin
                    mem_we = 1'b1;
                    mem_wd = {fkv_pkg::MARK_TOMB, r_key, r_len, r_hit_val};
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end else begin
                    n_status = fkv_pkg::ST_ABSENT;
                end
            end
            default: begin
                if (r_found) begin
                    mem_we = 1'b1;
                end else begin
                    n_status = fkv_pkg::ST_ABSENT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= fkv_pkg::t_kind'(i_kind);
            r_key  <= key_masked;
            r_len  <= len_sat;
            r_val  <= i_data_word[VW-1:0];
            r_hash <= fkv_pkg::FNV_BASIS;
            r_cnt  <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash <= product[31:0] ^ {24'h0, hash_byte};
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_cmd.probe_init) begin
            r_idx       <= r_hash[SW-1:0];
            r_stride    <= (r_hash[SW-1:0] == '0) ? SW'(1) : r_hash[SW-1:0];
            r_visits    <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.check) begin
            if (is_match) begin
                r_found   <= 1'b1;
                r_hit     <= r_idx;
                r_hit_val <= rd_val;
            end else if ((is_empty || is_tomb) && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_idx;
            end
            r_idx    <= r_idx + r_stride;
            r_visits <= r_visits + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.mem_read) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_live   <= '0;
        end else begin
            if (i_cmd.commit && mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (i_cmd.mem_read) begin
                r_rd_vld <= r_vld[r_idx];
            end
            if (i_cmd.commit) begin
                r_live <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status <= n_status;
            r_o_value  <= fkv_pkg::DATA_W'(n_value);
            r_o_total  <= n_live;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_value;
    assign o_entry_total = r_o_total;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(fkv_pkg::SLOTS))
        else $error("entry count above slot count");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_len <= LW'(fkv_pkg::MAX_KEY_BYTES))
        else $error("stored key length not saturated");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> r_visits < CW'(fkv_pkg::SLOTS))
        else $error("probe ran past slot count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_live))
        else $error("entry count moved outside commit");

endmodule
